// ===== hdl/assert_macros.svh =====
// assertion macros used by typed_time_ring_log
// no dependencies; expects clk_i and rst_ni in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge outside reset
`define TTRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every clock edge, reset included
`define TTRL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/ttrl_pkg.sv =====
// types and constants of the typed time ring log
// no dependencies
package ttrl_pkg;

  localparam int unsigned TYPE_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned KIND_W  = 2;

  // stored entry: type, time and value side by side in one ram word
  localparam int unsigned ENTRY_W = TYPE_W + TIME_W + VALUE_W;

  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NEWEST = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WIN_NF = 2'd2;
  localparam logic [KIND_W-1:0] KIND_WIN_OF = 2'd3;

  typedef struct packed {
    logic               found;
    logic [SLOT_W-1:0]  slot;
    logic [TYPE_W-1:0]  typ;
    logic [TIME_W-1:0]  tstamp;
    logic [VALUE_W-1:0] value;
  } res_t;

endpackage

// ===== hdl/ttrl_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ttrl_ram #(
  parameter int unsigned WIDTH = 72,
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/typed_time_ring_log.sv =====
// Typed time ring log: a write (kind 0) emits nothing; the ring holds up to
// ENTRIES-1 entries and drops the oldest when full. An accepted query examines
// one stored entry per cycle through the single ram read port: kinds 1 and 2
// scan at most the held entries, kind 3 scans back to the end of the window and
// then forward again from the oldest match, up to twice the held count. A done
// state closes the query. Results leave through an output register with a one-deep
// holding stage behind it; a full output stalls the scan when a further match
// arrives while the holding stage is occupied. The next item is taken once the last
// result of a query is registered.
// Depends on ttrl_pkg, ttrl_ram and assert_macros.svh.
`include "assert_macros.svh"

module typed_time_ring_log #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  entry_type_i,
  input  logic [31:0] entry_time_i,
  input  logic [31:0] entry_value_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] window_ms_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [5:0]  slot_index_o,
  output logic [7:0]  out_type_o,
  output logic [31:0] out_time_o,
  output logic [31:0] out_value_o,
  output logic        last_of_run_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST_SLOT = IW'(ENTRIES - 1);
  localparam logic [IW:0]   ENT_W     = (IW + 1)'(ENTRIES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [IW-1:0] head_q, head_d, tail_q, tail_d;
  logic [IW-1:0] k_q, k_d, slot_q, slot_d, count_q, count_d;
  logic [IW-1:0] old_k_q, old_k_d, old_slot_q, old_slot_d;
  logic          hit_q, hit_d, phase_b_q, phase_b_d;
  logic [1:0]    kind_q, kind_d;
  logic [7:0]    type_q, type_d;
  logic [31:0]   start_q, start_d;

  logic          hold_valid_q, hold_valid_d;
  ttrl_pkg::res_t hold_q, hold_d;
  logic          out_valid_q, out_valid_d;
  ttrl_pkg::res_t out_q, out_d;
  logic          out_last_q, out_last_d;

  logic                            in_xfer;
  logic                            ram_we;
  logic [ttrl_pkg::ENTRY_W-1:0]    ram_wdata, ram_rdata;
  logic [7:0]                      rd_type;
  logic [31:0]                     rd_time, rd_value;
  logic                            type_hit, too_old, out_free, last_k;
  logic                            emit_req, stall, advance;
  logic [IW-1:0]                   k_inc, head_inc, newest, count_now;
  ttrl_pkg::res_t                  cur_res;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  assign ram_we    = in_xfer && (kind_i == ttrl_pkg::KIND_WRITE);
  assign ram_wdata = {entry_type_i, entry_time_i, entry_value_i};

  ttrl_ram #(
    .WIDTH (ttrl_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i (ram_wdata),
    .raddr_i (slot_d),
    .rdata_o (ram_rdata)
  );

  assign {rd_type, rd_time, rd_value} = ram_rdata;

  assign type_hit = (rd_type == type_q);
  assign too_old  = (rd_time < start_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign k_inc    = k_q + IW'(1);
  assign last_k   = (k_inc == count_q);
  assign head_inc = (head_q == LAST_SLOT) ? '0 : head_q + IW'(1);
  assign newest   = (head_q == '0) ? LAST_SLOT : head_q - IW'(1);
  assign count_now = (head_q >= tail_q) ? head_q - tail_q
                                        : IW'({1'b0, head_q} + ENT_W - {1'b0, tail_q});

  always_comb begin
    cur_res.found  = 1'b1;
    cur_res.slot   = ttrl_pkg::SLOT_W'(slot_q);
    cur_res.typ    = rd_type;
    cur_res.tstamp = rd_time;
    cur_res.value  = rd_value;
  end

  // scan sequencer
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    k_d          = k_q;
    slot_d       = slot_q;
    count_d      = count_q;
    old_k_d      = old_k_q;
    old_slot_d   = old_slot_q;
    hit_d        = hit_q;
    phase_b_d    = phase_b_q;
    kind_d       = kind_q;
    type_d       = type_q;
    start_d      = start_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    emit_req     = 1'b0;
    stall        = 1'b0;
    advance      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (kind_i == ttrl_pkg::KIND_WRITE) begin
            head_d = head_inc;
            if (head_inc == tail_q) begin
              tail_d = (tail_q == LAST_SLOT) ? '0 : tail_q + IW'(1);
            end
          end else begin
            kind_d    = kind_i;
            type_d    = entry_type_i;
            start_d   = (window_ms_i > now_ms_i) ? '0 : now_ms_i - window_ms_i;
            count_d   = count_now;
            k_d       = '0;
            slot_d    = newest;
            hit_d     = 1'b0;
            phase_b_d = 1'b0;
            state_d   = (count_now == '0) ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (phase_b_q) begin
          // forward pass of an oldest-first query
          emit_req = type_hit;
          stall    = emit_req && hold_valid_q && !out_free;
          if (!stall) begin
            if (k_q == '0) begin
              state_d = ST_DONE;
            end else begin
              advance = 1'b1;
            end
          end
        end else if (kind_q == ttrl_pkg::KIND_NEWEST) begin
          if (type_hit) begin
            emit_req = 1'b1;
            state_d  = ST_DONE;
          end else if (last_k) begin
            state_d = ST_DONE;
          end else begin
            advance = 1'b1;
          end
        end else begin
          emit_req = type_hit && !too_old && (kind_q == ttrl_pkg::KIND_WIN_NF);
          stall    = emit_req && hold_valid_q && !out_free;
          if (!stall) begin
            if (type_hit && !too_old) begin
              hit_d      = 1'b1;
              old_k_d    = k_q;
              old_slot_d = slot_q;
            end
            if (too_old || last_k) begin
              if (kind_q == ttrl_pkg::KIND_WIN_OF && hit_d) begin
                // turn around at the oldest match and walk back to the newest
                phase_b_d = 1'b1;
                k_d       = old_k_d;
                slot_d    = old_slot_d;
              end else begin
                state_d = ST_DONE;
              end
            end else begin
              advance = 1'b1;
            end
          end
        end

        if (advance) begin
          if (phase_b_q) begin
            k_d    = k_q - IW'(1);
            slot_d = (slot_q == LAST_SLOT) ? '0 : slot_q + IW'(1);
          end else begin
            k_d    = k_inc;
            slot_d = (slot_q == '0) ? LAST_SLOT : slot_q - IW'(1);
          end
        end

        // one result is kept back so the final one can carry last_of_run
        if (emit_req && !stall) begin
          if (hold_valid_q) begin
            out_d       = hold_q;
            out_last_d  = 1'b0;
            out_valid_d = 1'b1;
          end
          hold_d       = cur_res;
          hold_valid_d = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d        = hold_valid_q ? hold_q : '0;
          out_last_d   = 1'b1;
          out_valid_d  = 1'b1;
          hold_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      hit_q        <= 1'b0;
      phase_b_q    <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      hit_q        <= hit_d;
      phase_b_q    <= phase_b_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    slot_q     <= slot_d;
    count_q    <= count_d;
    old_k_q    <= old_k_d;
    old_slot_q <= old_slot_d;
    kind_q     <= kind_d;
    type_q     <= type_d;
    start_q    <= start_d;
    hold_q     <= hold_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_q.found;
  assign slot_index_o  = out_q.slot;
  assign out_type_o    = out_q.typ;
  assign out_time_o    = out_q.tstamp;
  assign out_value_o   = out_q.value;
  assign last_of_run_o = out_last_q;

  `TTRL_ASSERT(a_write_keeps_gap,
    in_xfer && kind_i == ttrl_pkg::KIND_WRITE |=> head_q != tail_q,
    "ring head caught up with tail after a write")
  `TTRL_ASSERT(a_scan_in_range, state_q == ST_SCAN |-> k_q < count_q,
    "scan position beyond held entries")
  `TTRL_ASSERT(a_idle_hold_empty, state_q == ST_IDLE |-> !hold_valid_q,
    "result left behind in holding stage")
  `TTRL_ASSERT(a_nomatch_is_last, out_valid_q && !out_q.found |-> out_last_q,
    "no-match result not marked last")

endmodule
